### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dptr assertion failed");

// next-cycle implication, disabled while in reset
`define DPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dptr assertion failed");

`endif

### rtl/dptr_pkg.sv
// ----------------------------------------------------------------------------
// dptr_pkg
// Types and constants of the Doppler pitch tracker.
// ----------------------------------------------------------------------------
package dptr_pkg;

    // one tick request
    typedef struct packed {
        logic [31:0]        tick_length;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic signed [31:0] source_z;
        logic signed [31:0] listener_x;
        logic signed [31:0] listener_y;
        logic signed [31:0] listener_z;
        logic signed [31:0] listener_vel_x;
        logic signed [31:0] listener_vel_y;
        logic signed [31:0] listener_vel_z;
        logic               listener_valid;
        logic               source_playing;
    } in_item_t;

    // one result
    typedef struct packed {
        logic [19:0] pitch_multiplier;
        logic        tracking_active;
    } out_item_t;

    // configuration registers
    typedef struct packed {
        logic        positional_enable;
        logic [23:0] doppler_factor;
        logic [31:0] speed_of_sound;
        logic [15:0] velocity_smoothing;
    } cfg_t;

    // register indexes
    localparam logic [1:0] CFG_POSITIONAL = 2'd0;
    localparam logic [1:0] CFG_FACTOR     = 2'd1;
    localparam logic [1:0] CFG_SOUND      = 2'd2;
    localparam logic [1:0] CFG_SMOOTHING  = 2'd3;

    // request classes decided by the front end
    localparam logic [1:0] KIND_HOLD  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_TRACK = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        in_item_t   item;
    } entry_t;

    // divider interface
    localparam int DIV_W = 80;
    localparam int DVS_W = 60;

    typedef struct packed {
        logic             start;
        logic [6:0]       iters;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // fixed-point constants
    localparam logic [19:0] UNITY_Q16  = 20'd65536;
    localparam logic [16:0] SMOOTH_MAX = 17'd65470;
    localparam logic signed [67:0] FLOOR_Q32 = 68'sd42949673;
    localparam logic [DIV_W-1:0] MULT_MIN = 80'd8192;
    localparam logic [DIV_W-1:0] MULT_MAX = 80'd524288;

endpackage

### rtl/doppler_pitch_tracker_unit.sv
// ----------------------------------------------------------------------------
// doppler_pitch_tracker_unit
// Doppler pitch multiplier for one positional source: tracks the source
// velocity and forms the clamped Q4.16 pitch ratio once per tick.
// ----------------------------------------------------------------------------
//  channel | signals                                   | moves
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//  in      | in_valid, in_ready, in_data               | tick request
//  out     | out_valid, out_ready, out_data            | pitch result
//
//  Untracked, frozen and first ticks go straight from idle to the emit state.
//  A tracked tick is paced by the shared one-bit-per-cycle divider (three
//  velocity divides, two projections, at most one ratio) plus the 32-step
//  square root and the normalizing shifter.
//  Reset is asynchronous, active low; cfg_ready stays high.
//  The two-entry request queue keeps taking ticks while the back end or out
//  stalls; once it is full, in_ready drops.
// ----------------------------------------------------------------------------
module doppler_pitch_tracker_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  dptr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dptr_pkg::out_item_t out_data
);
    import dptr_pkg::*;

    cfg_t     cfg;
    entry_t   push_data;
    entry_t   pop_data;
    logic     push_valid;
    logic     push_ready;
    logic     pop_valid;
    logic     pop_ready;
    div_req_t div_req;
    div_rsp_t div_rsp;

    dptr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dptr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    dptr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dptr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_data    (pop_data),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/dptr_fifo.sv
// ----------------------------------------------------------------------------
// dptr_fifo
// Small request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dptr_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  dptr_pkg::entry_t  push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output dptr_pkg::entry_t  pop_data
);
    import dptr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t         mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/dptr_div.sv
// ----------------------------------------------------------------------------
// dptr_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dptr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  dptr_pkg::div_req_t  req,
    output dptr_pkg::div_rsp_t  rsp
);
    import dptr_pkg::*;

    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W:0]   rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [6:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W+1:0] rem_sh;
    logic             fits;

    // one restoring step; dividend is left aligned
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
        fits   = (rem_sh >= {2'b00, dvs_reg});
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? (DVS_W+1)'(rem_sh - {2'b00, dvs_reg}) : rem_sh[DVS_W:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### rtl/dptr_front.sv
// ----------------------------------------------------------------------------
// dptr_front
// Configuration registers and classification of incoming tick requests.
// ----------------------------------------------------------------------------
module dptr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  dptr_pkg::in_item_t in_data,
    output dptr_pkg::cfg_t     cfg,
    output logic               push_valid,
    input  logic               push_ready,
    output dptr_pkg::entry_t   push_data
);
    import dptr_pkg::*;

    cfg_t cfg_reg;
    logic idle_tick;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.positional_enable  <= 1'b1;
            cfg_reg.doppler_factor     <= 24'd65536;
            cfg_reg.speed_of_sound     <= 32'd22478848;
            cfg_reg.velocity_smoothing <= 16'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_POSITIONAL: cfg_reg.positional_enable  <= cfg_data[0];
                CFG_FACTOR:     cfg_reg.doppler_factor     <= cfg_data[23:0];
                CFG_SOUND:      cfg_reg.speed_of_sound     <= cfg_data;
                CFG_SMOOTHING:  cfg_reg.velocity_smoothing <= cfg_data[15:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // classify: frozen, reset-to-unity, or tracked
    assign idle_tick = !in_data.listener_valid || !in_data.source_playing ||
                       (in_data.tick_length == '0) || (cfg_reg.doppler_factor == '0) ||
                       (cfg_reg.speed_of_sound == '0);

    always_comb
    begin
        push_data.item = in_data;
        if (!cfg_reg.positional_enable)
        begin
            push_data.kind = KIND_HOLD;
        end
        else if (idle_tick)
        begin
            push_data.kind = KIND_RESET;
        end
        else
        begin
            push_data.kind = KIND_TRACK;
        end
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

### rtl/dptr_back.sv
// ----------------------------------------------------------------------------
// dptr_back
// Sequencer for velocity tracking, projection and pitch ratio.
// ----------------------------------------------------------------------------
module dptr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  dptr_pkg::cfg_t      cfg,
    input  logic                q_valid,
    output logic                q_ready,
    input  dptr_pkg::entry_t    q_data,
    output dptr_pkg::div_req_t  div_req,
    input  dptr_pkg::div_rsp_t  div_rsp,
    output logic                out_valid,
    input  logic                out_ready,
    output dptr_pkg::out_item_t out_data
);
    import dptr_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_VDIV  = 5'd1;
    localparam logic [4:0] S_VWAIT = 5'd2;
    localparam logic [4:0] S_SM0   = 5'd3;
    localparam logic [4:0] S_SM1   = 5'd4;
    localparam logic [4:0] S_SM2   = 5'd5;
    localparam logic [4:0] S_DIR   = 5'd6;
    localparam logic [4:0] S_NORM  = 5'd7;
    localparam logic [4:0] S_DOT   = 5'd8;
    localparam logic [4:0] S_SQRT  = 5'd9;
    localparam logic [4:0] S_PL    = 5'd10;
    localparam logic [4:0] S_PLW   = 5'd11;
    localparam logic [4:0] S_PS    = 5'd12;
    localparam logic [4:0] S_PSW   = 5'd13;
    localparam logic [4:0] S_NUM   = 5'd14;
    localparam logic [4:0] S_DEN   = 5'd15;
    localparam logic [4:0] S_RAT   = 5'd16;
    localparam logic [4:0] S_RCMP  = 5'd17;
    localparam logic [4:0] S_RW    = 5'd18;
    localparam logic [4:0] S_EMIT  = 5'd19;

    // control state
    logic [4:0]         state_reg;
    logic [4:0]         state_next;
    logic               started_reg;
    logic [19:0]        mult_reg;
    logic signed [31:0] last_reg [3];
    logic signed [31:0] sv_reg [3];
    logic [1:0]         ax_reg;
    logic [3:0]         j_reg;
    logic [4:0]         sq_cnt_reg;
    logic               out_valid_reg;

    // datapath
    in_item_t           item_reg;
    logic               dneg_reg;
    logic signed [31:0] raw_reg;
    logic signed [67:0] acc_reg;
    logic signed [67:0] prod_reg;
    logic [32:0]        mag_reg [3];
    logic [2:0]         neg_reg;
    logic [32:0]        m_reg;
    logic [63:0]        len_reg;
    logic signed [65:0] dotl_reg;
    logic signed [65:0] dots_reg;
    logic [63:0]        sq_v_reg;
    logic [63:0]        sq_r_reg;
    logic [63:0]        sq_bit_reg;
    logic signed [33:0] vl_reg;
    logic signed [33:0] vs_reg;
    logic [58:0]        un_reg;
    logic [58:0]        ud_reg;
    logic [19:0]        res_mult_reg;
    logic               res_act_reg;
    out_item_t          out_data_reg;

    // combinational helpers
    logic [1:0]         k_idx;
    logic [1:0]         sv_idx;
    logic signed [31:0] sv_sel;
    logic signed [31:0] spos_sel;
    logic signed [31:0] lvel_sel;
    logic [32:0]        mag_sel;
    logic signed [33:0] dn_sel;
    logic signed [32:0] diff;
    logic [32:0]        ad;
    logic [16:0]        s17;
    logic [16:0]        w17;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [68:0] sm_sum;
    logic signed [68:0] sm_shr;
    logic signed [31:0] sm_sat;
    logic [56:0]        qv;
    logic signed [31:0] raw_c;
    logic signed [32:0] dir_d [3];
    logic [32:0]        dir_mag [3];
    logic [2:0]         dir_neg;
    logic [32:0]        dir_m;
    logic [63:0]        sq_t;
    logic [65:0]        dabs;
    logic signed [33:0] pq;
    logic signed [67:0] c_q32;
    logic signed [67:0] nd_raw;
    logic [58:0]        nd_floor;
    logic [DIV_W-1:0]   rq;
    logic [19:0]        rq_clamp;
    logic               emit_ok;

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign emit_ok   = !out_valid_reg || out_ready;

    // lane selects
    always_comb
    begin
        case (j_reg)
            4'd0, 4'd3, 4'd6: k_idx = 2'd0;
            4'd1, 4'd4, 4'd7: k_idx = 2'd1;
            default:          k_idx = 2'd2;
        endcase
        sv_idx = (state_reg == S_DOT) ? k_idx : ax_reg;
        sv_sel = sv_reg[sv_idx];
        case (ax_reg)
            2'd0:    spos_sel = item_reg.source_x;
            2'd1:    spos_sel = item_reg.source_y;
            default: spos_sel = item_reg.source_z;
        endcase
        case (k_idx)
            2'd0:    lvel_sel = item_reg.listener_vel_x;
            2'd1:    lvel_sel = item_reg.listener_vel_y;
            default: lvel_sel = item_reg.listener_vel_z;
        endcase
        mag_sel = mag_reg[k_idx];
        dn_sel  = neg_reg[k_idx] ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});
    end

    // position delta and smoothing weights
    always_comb
    begin
        diff = $signed({spos_sel[31], spos_sel})
             - $signed({last_reg[ax_reg][31], last_reg[ax_reg]});
        ad   = diff[32] ? 33'(-diff) : 33'(diff);
        s17  = ({1'b0, cfg.velocity_smoothing} > SMOOTH_MAX) ? SMOOTH_MAX
                                                             : {1'b0, cfg.velocity_smoothing};
        w17  = 17'd65536 - s17;
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SM0:
            begin
                mul_a = 34'(sv_sel);
                mul_b = $signed({17'd0, s17});
            end
            S_SM1:
            begin
                mul_a = 34'(raw_reg);
                mul_b = $signed({17'd0, w17});
            end
            S_DOT:
            begin
                if (j_reg < 4'd3)
                begin
                    mul_a = $signed({1'b0, mag_sel});
                    mul_b = $signed({1'b0, mag_sel});
                end
                else if (j_reg < 4'd6)
                begin
                    mul_a = 34'(lvel_sel);
                    mul_b = dn_sel;
                end
                else
                begin
                    mul_a = 34'(sv_sel);
                    mul_b = dn_sel;
                end
            end
            S_NUM:
            begin
                mul_a = $signed({10'd0, cfg.doppler_factor});
                mul_b = vl_reg;
            end
            S_DEN:
            begin
                mul_a = $signed({10'd0, cfg.doppler_factor});
                mul_b = vs_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // raw velocity from the divider, saturated
    always_comb
    begin
        qv = div_rsp.quotient[56:0];
        if (qv >= 57'h80000000)
        begin
            raw_c = dneg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        else
        begin
            raw_c = dneg_reg ? -$signed(qv[31:0]) : $signed(qv[31:0]);
        end
    end

    // one-pole smoothing, rounded, floored and saturated
    always_comb
    begin
        sm_sum = 69'(acc_reg) + 69'(prod_reg) + 69'sd32768;
        sm_shr = sm_sum >>> 16;
        if ((&sm_shr[68:31]) || !(|sm_shr[68:31]))
        begin
            sm_sat = sm_shr[31:0];
        end
        else
        begin
            sm_sat = sm_shr[68] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
    end

    // source-to-listener direction
    always_comb
    begin
        dir_d[0] = $signed({item_reg.listener_x[31], item_reg.listener_x})
                 - $signed({item_reg.source_x[31], item_reg.source_x});
        dir_d[1] = $signed({item_reg.listener_y[31], item_reg.listener_y})
                 - $signed({item_reg.source_y[31], item_reg.source_y});
        dir_d[2] = $signed({item_reg.listener_z[31], item_reg.listener_z})
                 - $signed({item_reg.source_z[31], item_reg.source_z});
        for (int i = 0; i < 3; i++)
        begin
            dir_neg[i] = dir_d[i][32];
            dir_mag[i] = dir_d[i][32] ? 33'(-dir_d[i]) : 33'(dir_d[i]);
        end
        dir_m = (dir_mag[0] > dir_mag[1]) ? dir_mag[0] : dir_mag[1];
        dir_m = (dir_mag[2] > dir_m) ? dir_mag[2] : dir_m;
    end

    // square root step, projection result, num/den, ratio clamp
    always_comb
    begin
        sq_t     = sq_r_reg + sq_bit_reg;
        dabs     = (state_reg == S_PL) ? (dotl_reg[65] ? 66'(-dotl_reg) : 66'(dotl_reg))
                                       : (dots_reg[65] ? 66'(-dots_reg) : 66'(dots_reg));
        pq       = $signed(div_rsp.quotient[33:0]);
        c_q32    = $signed({20'd0, cfg.speed_of_sound, 16'd0});
        nd_raw   = c_q32 - prod_reg;
        nd_floor = (nd_raw < FLOOR_Q32) ? FLOOR_Q32[58:0] : nd_raw[58:0];
        rq       = div_rsp.quotient;
        if (rq < MULT_MIN)
        begin
            rq_clamp = MULT_MIN[19:0];
        end
        else if (rq > MULT_MAX)
        begin
            rq_clamp = MULT_MAX[19:0];
        end
        else
        begin
            rq_clamp = rq[19:0];
        end
    end

    // divider requests
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.iters    = 7'd80;
        div_req.dividend = {5'd0, un_reg, 16'd0};
        div_req.divisor  = {1'b0, ud_reg};
        case (state_reg)
            S_VDIV:
            begin
                div_req.start    = 1'b1;
                div_req.iters    = 7'd57;
                div_req.dividend = {ad, 47'd0};
                div_req.divisor  = {28'd0, item_reg.tick_length};
            end
            S_PL, S_PS:
            begin
                div_req.start    = 1'b1;
                div_req.iters    = 7'd64;
                div_req.dividend = {dabs[63:0], 16'd0};
                div_req.divisor  = {29'd0, sq_r_reg[30:0]};
            end
            S_RCMP:
            begin
                div_req.start = !({3'd0, un_reg} >= {ud_reg, 3'd0}) &&
                                !({un_reg, 3'd0} <= {3'd0, ud_reg});
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.kind == KIND_TRACK && started_reg)
                    begin
                        state_next = S_VDIV;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_VDIV:  state_next = S_VWAIT;
            S_VWAIT: state_next = div_rsp.done ? S_SM0 : S_VWAIT;
            S_SM0:   state_next = S_SM1;
            S_SM1:   state_next = S_SM2;
            S_SM2:   state_next = (ax_reg == 2'd2) ? S_DIR : S_VDIV;
            S_DIR:   state_next = (dir_m == '0) ? S_EMIT : S_NORM;
            S_NORM:
            begin
                if (m_reg[32:30] == '0 && m_reg[29])
                begin
                    state_next = S_DOT;
                end
            end
            S_DOT:   state_next = (j_reg == 4'd9) ? S_SQRT : S_DOT;
            S_SQRT:  state_next = (sq_cnt_reg == 5'd31) ? S_PL : S_SQRT;
            S_PL:    state_next = S_PLW;
            S_PLW:   state_next = div_rsp.done ? S_PS : S_PLW;
            S_PS:    state_next = S_PSW;
            S_PSW:   state_next = div_rsp.done ? S_NUM : S_PSW;
            S_NUM:   state_next = S_DEN;
            S_DEN:   state_next = S_RAT;
            S_RAT:   state_next = S_RCMP;
            S_RCMP:  state_next = div_req.start ? S_RW : S_EMIT;
            S_RW:    state_next = div_rsp.done ? S_EMIT : S_RW;
            S_EMIT:  state_next = emit_ok ? S_IDLE : S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    // control and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            mult_reg      <= UNITY_Q16;
            ax_reg        <= '0;
            j_reg         <= '0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                last_reg[i] <= '0;
                sv_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // result register handshake
            if (state_reg == S_EMIT && emit_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    ax_reg <= '0;
                    if (q_valid)
                    begin
                        if (q_data.kind == KIND_RESET)
                        begin
                            mult_reg    <= UNITY_Q16;
                            started_reg <= 1'b0;
                        end
                        else if (q_data.kind == KIND_TRACK && !started_reg)
                        begin
                            last_reg[0] <= q_data.item.source_x;
                            last_reg[1] <= q_data.item.source_y;
                            last_reg[2] <= q_data.item.source_z;
                            for (int i = 0; i < 3; i++)
                            begin
                                sv_reg[i] <= '0;
                            end
                            started_reg <= 1'b1;
                            mult_reg    <= UNITY_Q16;
                        end
                    end
                end
                S_SM2:
                begin
                    sv_reg[ax_reg]   <= sm_sat;
                    last_reg[ax_reg] <= spos_sel;
                    ax_reg           <= ax_reg + 1'b1;
                end
                S_DIR:
                begin
                    j_reg <= '0;
                    if (dir_m == '0)
                    begin
                        mult_reg <= UNITY_Q16;
                    end
                end
                S_DOT:
                begin
                    j_reg      <= j_reg + 1'b1;
                    sq_cnt_reg <= '0;
                end
                S_SQRT:
                begin
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                end
                S_RCMP:
                begin
                    if (!div_req.start)
                    begin
                        mult_reg <= ({3'd0, un_reg} >= {ud_reg, 3'd0}) ? MULT_MAX[19:0]
                                                                       : MULT_MIN[19:0];
                    end
                end
                S_RW:
                begin
                    if (div_rsp.done)
                    begin
                        mult_reg <= rq_clamp;
                    end
                end
                default:
                begin
                    ax_reg <= ax_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                item_reg    <= q_data.item;
                res_act_reg <= 1'b0;
                res_mult_reg <= (q_data.kind == KIND_HOLD) ? mult_reg : UNITY_Q16;
            end
            S_VDIV:
            begin
                dneg_reg <= diff[32];
            end
            S_VWAIT:
            begin
                raw_reg <= raw_c;
            end
            S_SM1:
            begin
                acc_reg <= prod_reg;
            end
            S_DIR:
            begin
                mag_reg      <= dir_mag;
                neg_reg      <= dir_neg;
                m_reg        <= dir_m;
                res_mult_reg <= UNITY_Q16;
                res_act_reg  <= 1'b0;
            end
            S_NORM:
            begin
                if (m_reg[32:30] != '0)
                begin
                    m_reg <= m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (!m_reg[29])
                begin
                    m_reg <= m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            S_DOT:
            begin
                if (j_reg == 4'd0)
                begin
                    len_reg  <= '0;
                    dotl_reg <= '0;
                    dots_reg <= '0;
                end
                else if (j_reg < 4'd4)
                begin
                    len_reg <= len_reg + prod_reg[63:0];
                end
                else if (j_reg < 4'd7)
                begin
                    dotl_reg <= dotl_reg + prod_reg[65:0];
                end
                else
                begin
                    dots_reg <= dots_reg + prod_reg[65:0];
                end
                sq_v_reg   <= len_reg;
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'h4000000000000000;
            end
            S_SQRT:
            begin
                if (sq_v_reg >= sq_t)
                begin
                    sq_v_reg <= sq_v_reg - sq_t;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            S_PLW:
            begin
                if (div_rsp.done)
                begin
                    vl_reg <= dotl_reg[65] ? -pq : pq;
                end
            end
            S_PSW:
            begin
                if (div_rsp.done)
                begin
                    vs_reg <= dots_reg[65] ? -pq : pq;
                end
            end
            S_DEN:
            begin
                un_reg <= nd_floor;
            end
            S_RAT:
            begin
                ud_reg <= nd_floor;
            end
            S_RCMP:
            begin
                res_act_reg  <= 1'b1;
                res_mult_reg <= ({3'd0, un_reg} >= {ud_reg, 3'd0}) ? MULT_MAX[19:0]
                                                                   : MULT_MIN[19:0];
            end
            S_RW:
            begin
                res_mult_reg <= rq_clamp;
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_data_reg.pitch_multiplier <= res_mult_reg;
                    out_data_reg.tracking_active  <= res_act_reg;
                end
            end
            default:
            begin
                res_act_reg <= res_act_reg;
            end
        endcase
    end

endmodule

### rtl/dptr_checker.sv
// ----------------------------------------------------------------------------
// dptr_checker
// Port-level checks of the Doppler pitch tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dptr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_ready,
    input logic                out_valid,
    input logic                out_ready,
    input dptr_pkg::out_item_t out_data
);
    import dptr_pkg::*;

    // results always inside the clamp window
    `DPT_ASSERT_IMPL(a_mult_range, clk, rst_n, out_valid, (out_data.pitch_multiplier >= 20'd8192 && out_data.pitch_multiplier <= 20'd524288))

    // register port never back-pressures
    `DPT_ASSERT_IMPL(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

    // stalled result stays put
    `DPT_ASSERT_NEXT(a_out_hold, clk, rst_n, (out_valid && !out_ready), out_valid)
    `DPT_ASSERT_NEXT(a_out_stable, clk, rst_n, (out_valid && !out_ready), $stable(out_data))

endmodule

bind doppler_pitch_tracker_unit dptr_checker u_dptr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### test/tb_doppler_pitch_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_doppler_pitch_tracker_unit
// Self-checking bench for the Doppler pitch tracker: drives tick requests and
// register writes over valid/ready, predicts each pitch result in a local
// fixed-point model and compares every result in order.
// ----------------------------------------------------------------------------
module tb_doppler_pitch_tracker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import dptr_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 1000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;

    // predictor state
    logic        m_positional;
    logic [23:0] m_factor;
    logic [31:0] m_sound;
    logic [15:0] m_smoothing;
    longint      m_last_pos [3];
    longint      m_velocity [3];
    bit          m_started;
    logic [19:0] m_multiplier;

    out_item_t   pending_pitch [$];
    int          error_count;
    int          idle_pct;
    int          stall_left;

    doppler_pitch_tracker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor integer square root
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // pitch ratio for one tick, updates the tracking state
    function automatic out_item_t doppler_pitch(in_item_t t);
        out_item_t          res;
        longint             spos [3];
        longint             lpos [3];
        longint             diff;
        longint             raw;
        longint             acc;
        longint             sw;
        longint unsigned    ad;
        longint unsigned    qv;
        longint unsigned    mag [3];
        longint unsigned    m;
        longint unsigned    sumsq;
        longint unsigned    len;
        longint unsigned    un;
        longint unsigned    ud;
        longint unsigned    q;
        longint unsigned    r;
        bit                 negd [3];
        logic signed [71:0] dn;
        logic signed [71:0] lv;
        logic signed [71:0] sv;
        logic signed [71:0] dot_l;
        logic signed [71:0] dot_s;
        logic signed [71:0] vl;
        logic signed [71:0] vs;
        logic signed [71:0] num;
        logic signed [71:0] den;
        logic signed [71:0] lenw;
        logic signed [71:0] cw;
        logic signed [71:0] fw;
        spos[0] = t.source_x;   spos[1] = t.source_y;   spos[2] = t.source_z;
        lpos[0] = t.listener_x; lpos[1] = t.listener_y; lpos[2] = t.listener_z;
        res.tracking_active = 1'b0;
        res.pitch_multiplier = UNITY_Q16;
        // frozen source
        if (!m_positional)
        begin
            res.pitch_multiplier = m_multiplier;
            return res;
        end
        // invalid, idle or disabled tick
        if (!t.listener_valid || !t.source_playing || t.tick_length == 0 ||
            m_factor == 0 || m_sound == 0)
        begin
            m_multiplier = UNITY_Q16;
            m_started = 0;
            return res;
        end
        // first tracked tick latches the position
        if (!m_started)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_last_pos[i] = spos[i];
                m_velocity[i] = 0;
            end
            m_started = 1;
            m_multiplier = UNITY_Q16;
            return res;
        end
        // smoothed source velocity
        sw = (m_smoothing > 16'd65470) ? 65470 : longint'(m_smoothing);
        for (int i = 0; i < 3; i++)
        begin
            diff = spos[i] - m_last_pos[i];
            ad = (diff < 0) ? -diff : diff;
            qv = (ad << 24) / longint'(t.tick_length);
            if (qv > 64'd4294967296)
                qv = 64'd4294967296;
            raw = sat32((diff < 0) ? -longint'(qv) : longint'(qv));
            acc = m_velocity[i] * sw + raw * (65536 - sw) + 32768;
            m_velocity[i] = sat32(acc >>> 16);
            m_last_pos[i] = spos[i];
        end
        // direction from source to listener
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            diff = lpos[i] - spos[i];
            negd[i] = diff < 0;
            mag[i] = negd[i] ? -diff : diff;
            if (mag[i] > m)
                m = mag[i];
        end
        if (m == 0)
        begin
            m_multiplier = UNITY_Q16;
            return res;
        end
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 29))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
                mag[i] = mag[i] << 1;
        end
        // projections
        sumsq = 0;
        dot_l = 0;
        dot_s = 0;
        for (int i = 0; i < 3; i++)
        begin
            dn = $signed({8'd0, mag[i]});
            if (negd[i])
                dn = -dn;
            sumsq = sumsq + mag[i] * mag[i];
            lv = (i == 0) ? t.listener_vel_x : (i == 1) ? t.listener_vel_y : t.listener_vel_z;
            sv = m_velocity[i];
            dot_l = dot_l + lv * dn;
            dot_s = dot_s + sv * dn;
        end
        len = isqrt(sumsq);
        lenw = $signed({8'd0, len});
        vl = dot_l / lenw;
        vs = dot_s / lenw;
        // ratio with floors and clamp
        cw = $signed({24'd0, m_sound, 16'd0});
        fw = $signed({48'd0, m_factor});
        num = cw - fw * vl;
        den = cw - fw * vs;
        if (num < FLOOR_Q32)
            num = FLOOR_Q32;
        if (den < FLOOR_Q32)
            den = FLOOR_Q32;
        un = num[63:0];
        ud = den[63:0];
        if (un >= ud * 8)
            q = 524288;
        else if (un * 8 <= ud)
            q = 8192;
        else
        begin
            q = un / ud;
            r = un % ud;
            for (int i = 0; i < 16; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= ud)
                begin
                    r = r - ud;
                    q = q | 1;
                end
            end
            if (q < 8192)
                q = 8192;
            if (q > 524288)
                q = 524288;
        end
        m_multiplier = q[19:0];
        res.pitch_multiplier = q[19:0];
        res.tracking_active = 1'b1;
        return res;
    endfunction

    // monitor: results first, then new requests and register writes
    always @(posedge clk)
    begin
        out_item_t exp_item;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pitch.size() == 0)
            begin
                $display("%0t: unexpected result, actual mult=%0d active=%0b",
                         $time, out_data.pitch_multiplier, out_data.tracking_active);
                error_count++;
            end
            else
            begin
                exp_item = pending_pitch.pop_front();
                if (out_data.pitch_multiplier !== exp_item.pitch_multiplier)
                begin
                    $display("%0t: pitch_multiplier expected %0d actual %0d", $time,
                             exp_item.pitch_multiplier, out_data.pitch_multiplier);
                    error_count++;
                end
                if (out_data.tracking_active !== exp_item.tracking_active)
                begin
                    $display("%0t: tracking_active expected %0b actual %0b", $time,
                             exp_item.tracking_active, out_data.tracking_active);
                    error_count++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            pending_pitch.insert(pending_pitch.size(), doppler_pitch(in_data));
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POSITIONAL: m_positional = cfg_data[0];
                CFG_FACTOR:     m_factor = cfg_data[23:0];
                CFG_SOUND:      m_sound = cfg_data;
                CFG_SMOOTHING:  m_smoothing = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // receiver: random stalls, quiet stretch and long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("FAIL doppler_pitch_tracker_unit");
                $finish;
            end
        end
    end

    // one tick request
    task automatic send_tick(in_item_t t);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_pitch.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write while idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic pos, logic [23:0] f, logic [31:0] c, logic [15:0] s);
        write_reg(CFG_POSITIONAL, {31'd0, pos});
        write_reg(CFG_FACTOR, {8'd0, f});
        write_reg(CFG_SOUND, c);
        write_reg(CFG_SMOOTHING, {16'd0, s});
    endtask

    function automatic in_item_t tracked_tick(logic [31:0] tick, logic signed [31:0] sx,
                                              logic signed [31:0] lx,
                                              logic signed [31:0] vx);
        in_item_t t;
        t = '0;
        t.tick_length = tick;
        t.source_x = sx;
        t.source_y = sx >>> 1;
        t.source_z = -sx;
        t.listener_x = lx;
        t.listener_y = 32'sd12345;
        t.listener_z = -lx;
        t.listener_vel_x = vx;
        t.listener_vel_y = -vx;
        t.listener_vel_z = vx >>> 2;
        t.listener_valid = 1'b1;
        t.source_playing = 1'b1;
        return t;
    endfunction

    function automatic in_item_t noise_tick();
        in_item_t t;
        t.tick_length = $urandom;
        t.source_x = $urandom;
        t.source_y = $urandom;
        t.source_z = $urandom;
        t.listener_x = $urandom;
        t.listener_y = $urandom;
        t.listener_z = $urandom;
        t.listener_vel_x = $urandom;
        t.listener_vel_y = $urandom;
        t.listener_vel_z = $urandom;
        t.listener_valid = $urandom_range(3) != 0;
        t.source_playing = $urandom_range(3) != 0;
        return t;
    endfunction

    // special cases and field extremes
    task automatic test_directed();
        in_item_t t;
        t = tracked_tick(32'd279620, 32'sd0, 32'sd655360, 32'sd0);
        t.listener_valid = 1'b0;
        send_tick(t);
        send_tick(tracked_tick(32'd279620, 32'sd0, 32'sd655360, 32'sd0));
        send_tick(tracked_tick(32'd279620, 32'sd65536, 32'sd655360, 32'sd0));
        // coincident positions
        t = tracked_tick(32'd279620, 32'sd131072, 32'sd131072, 32'sd0);
        t.listener_y = t.source_y;
        send_tick(t);
        // fast approach and fast recede hit the clamps
        send_tick(tracked_tick(32'd1, -32'sd2147483648, 32'sd2147483647, 32'sh7fffffff));
        send_tick(tracked_tick(32'hffffffff, 32'sd2147483647, -32'sd2147483648,
                               -32'sd2147483648));
        send_tick(tracked_tick(32'd1, -32'sd2147483648, 32'sd2147483647, -32'sd2147483648));
        // zero tick, not playing
        send_tick(tracked_tick(32'd0, 32'sd0, 32'sd65536, 32'sd0));
        t = tracked_tick(32'd279620, 32'sd0, 32'sd65536, 32'sd0);
        t.source_playing = 1'b0;
        send_tick(t);
        send_tick(tracked_tick(32'd279620, 32'sd100, 32'sd65536, 32'sd1000));
        send_tick(tracked_tick(32'd279620, 32'sd9000, 32'sd65536, 32'sd1000));
        // frozen source keeps the last multiplier
        write_reg(CFG_POSITIONAL, 32'd0);
        send_tick(tracked_tick(32'd279620, 32'sd50000, 32'sd65536, 32'sd1000));
        send_tick(noise_tick());
        write_reg(CFG_POSITIONAL, 32'd1);
        // zero factor and zero speed disable
        write_reg(CFG_FACTOR, 32'd0);
        send_tick(tracked_tick(32'd279620, 32'sd0, 32'sd65536, 32'sd0));
        set_config(1'b1, 24'hffffff, 32'd0, 16'hffff);
        send_tick(tracked_tick(32'd279620, 32'sd0, 32'sd65536, 32'sd0));
        set_config(1'b1, 24'hffffff, 32'hffffffff, 16'hffff);
        for (int i = 0; i < 4; i++)
            send_tick(tracked_tick(32'd27962, 32'sd4000000 * i, -32'sd300000, 32'sd70000));
        set_config(1'b1, 24'd65536, 32'd22478848, 16'd0);
        drain();
    endtask

    // random phases over several register settings
    task automatic test_random();
        in_item_t        t;
        logic signed [31:0] pos [3];
        logic signed [31:0] step [3];
        int              shift;
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: set_config(1'b1, 24'd65536, 32'd22478848, 16'd0);
                1: set_config(1'b1, 24'hffffff, 32'd22478848, 16'hffff);
                2: set_config(1'b1, 24'd1, 32'hffffffff, 16'd65470);
                3: set_config(1'b1, 24'd3000000, 32'd65536, 16'd32768);
                4: set_config(1'b1, 24'($urandom_range(24'hffffff, 1)), $urandom,
                              16'($urandom));
                5: set_config(1'b1, 24'($urandom_range(24'hffff, 1)),
                              $urandom_range(32'h1ffffff, 1),
                              16'($urandom_range(65535, 65400)));
                default: set_config(1'b0, 24'd65536, 32'd22478848, 16'd100);
            endcase
            idle_pct = (phase == 2) ? 0 : 8;
            shift = $urandom_range(16, 0);
            for (int k = 0; k < 3; k++)
            begin
                pos[k] = $signed($urandom) >>> shift;
                step[k] = $signed($urandom) >>> ($urandom_range(24, 8));
            end
            for (int n = 0; n < 190; n++)
            begin
                if ($urandom_range(99) < 12)
                    t = noise_tick();
                else
                begin
                    for (int k = 0; k < 3; k++)
                        pos[k] = pos[k] + step[k];
                    t.tick_length = $urandom_range(32'h4000000, 1);
                    t.source_x = pos[0];
                    t.source_y = pos[1];
                    t.source_z = pos[2];
                    t.listener_x = $signed($urandom) >>> shift;
                    t.listener_y = $signed($urandom) >>> shift;
                    t.listener_z = $signed($urandom) >>> shift;
                    t.listener_vel_x = $signed($urandom) >>> $urandom_range(20, 4);
                    t.listener_vel_y = $signed($urandom) >>> $urandom_range(20, 4);
                    t.listener_vel_z = $signed($urandom) >>> $urandom_range(20, 4);
                    t.listener_valid = $urandom_range(49) != 0;
                    t.source_playing = $urandom_range(49) != 0;
                end
                send_tick(t);
            end
        end
        idle_pct = 8;
        set_config(1'b1, 24'd65536, 32'd22478848, 16'd0);
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        stall_left = 3000;
        for (int n = 0; n < 12; n++)
            send_tick(tracked_tick(32'd279620, 32'sd7000 * n, 32'sd900000, 32'sd2000));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POSITIONAL;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        error_count = 0;
        idle_pct = 8;
        stall_left = 0;
        m_positional = 1'b1;
        m_factor = 24'd65536;
        m_sound = 32'd22478848;
        m_smoothing = 16'd0;
        for (int i = 0; i < 3; i++)
        begin
            m_last_pos[i] = 0;
            m_velocity[i] = 0;
        end
        m_started = 0;
        m_multiplier = UNITY_Q16;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_pitch.size() == 0)
            $display("PASS doppler_pitch_tracker_unit");
        else
            $display("FAIL doppler_pitch_tracker_unit");
        $finish;
    end

endmodule
